### design/srdb_pkg.sv
// ----------------------------------------------------------------------------
// srdb_pkg - shared types and constants
// Request codes, field widths, sequencer states and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package srdb_pkg;

  // fixed widths of the request and result fields
  localparam int IN_SET_W  = 11;
  localparam int IN_WAY_W  = 4;
  localparam int PC_W      = 64;
  localparam int MASK_W    = 16;
  localparam int OUT_WAY_W = 4;

  // number of sets that an 11-bit set index can address
  localparam int SET_SPAN  = 2048;

  // request codes
  localparam logic [1:0] CMD_VICTIM = 2'd0;
  localparam logic [1:0] CMD_HIT    = 2'd1;
  localparam logic [1:0] CMD_FILL   = 2'd2;
  localparam logic [1:0] CMD_DECAY  = 2'd3;

  // counter limits
  localparam logic [1:0] RRPV_MAX    = 2'd3;
  localparam logic [1:0] DEAD_MAX    = 2'd3;
  localparam logic [1:0] REUSE_MAX   = 2'd3;
  localparam logic [1:0] REUSE_HOT   = 2'd2;
  localparam logic [1:0] REUSE_RESET = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_PENALTY,
    ST_DECAY_RD,
    ST_DECAY_WR
  } state_t;

  typedef enum logic [1:0] {
    ROW_WR_NONE,
    ROW_WR_CLEAR,
    ROW_WR_UPDATE,
    ROW_WR_DECAY
  } row_wr_t;

  typedef enum logic [1:0] {
    REUSE_WR_NONE,
    REUSE_WR_INC,
    REUSE_WR_DEC
  } reuse_wr_t;

  typedef struct packed {
    logic      capture;
    logic      row_rd_en;
    logic      row_rd_sweep;
    row_wr_t   row_wr_op;
    logic      reuse_rd_en;
    logic      reuse_rd_old;
    reuse_wr_t reuse_wr_op;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] req_cmd;
    logic       way_ok;
    logic       lift_needed;
    logic       penalty;
    logic       cnt_last;
    logic       out_free;
  } dp_status_t;

endpackage

### design/srdb_ctrl.sv
// ----------------------------------------------------------------------------
// srdb_ctrl - request sequencer
// Runs the clearing pass after reset, the per-request row read, decide and
// write back, the reuse penalty step and the decay sweep over all sets.
// ----------------------------------------------------------------------------
module srdb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_cmd,
  input  srdb_pkg::dp_status_t   status,
  output srdb_pkg::ctrl_cmd_t    cmd
);

  srdb_pkg::state_t state_r;
  srdb_pkg::state_t state_nxt;
  logic             accept;
  logic             do_update;

  assign in_stall = (state_r != srdb_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign do_update =
    ((status.req_cmd == srdb_pkg::CMD_VICTIM) && status.lift_needed) ||
    (((status.req_cmd == srdb_pkg::CMD_HIT) || (status.req_cmd == srdb_pkg::CMD_FILL)) &&
     status.way_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srdb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srdb_pkg::ST_CLEAR: begin
        if (status.cnt_last) begin
          state_nxt = srdb_pkg::ST_IDLE;
        end
      end
      srdb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == srdb_pkg::CMD_DECAY) ? srdb_pkg::ST_DECAY_RD
                                                      : srdb_pkg::ST_EVAL;
        end
      end
      srdb_pkg::ST_EVAL: begin
        if (status.out_free) begin
          if ((status.req_cmd == srdb_pkg::CMD_FILL) && status.penalty) begin
            state_nxt = srdb_pkg::ST_PENALTY;
          end else begin
            state_nxt = srdb_pkg::ST_IDLE;
          end
        end
      end
      srdb_pkg::ST_PENALTY: begin
        state_nxt = srdb_pkg::ST_IDLE;
      end
      srdb_pkg::ST_DECAY_RD: begin
        state_nxt = srdb_pkg::ST_DECAY_WR;
      end
      srdb_pkg::ST_DECAY_WR: begin
        if (status.cnt_last) begin
          state_nxt = srdb_pkg::ST_EVAL;
        end else begin
          state_nxt = srdb_pkg::ST_DECAY_RD;
        end
      end
      default: begin
        state_nxt = srdb_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd.capture      = 1'b0;
    cmd.row_rd_en    = 1'b0;
    cmd.row_rd_sweep = 1'b0;
    cmd.row_wr_op    = srdb_pkg::ROW_WR_NONE;
    cmd.reuse_rd_en  = 1'b0;
    cmd.reuse_rd_old = 1'b0;
    cmd.reuse_wr_op  = srdb_pkg::REUSE_WR_NONE;
    cmd.cnt_clr      = 1'b0;
    cmd.cnt_inc      = 1'b0;
    cmd.res_load     = 1'b0;
    case (state_r)
      srdb_pkg::ST_CLEAR: begin
        cmd.row_wr_op = srdb_pkg::ROW_WR_CLEAR;
        cmd.cnt_clr   = status.cnt_last;
        cmd.cnt_inc   = !status.cnt_last;
      end
      srdb_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.capture     = 1'b1;
          cmd.row_rd_en   = 1'b1;
          cmd.reuse_rd_en = 1'b1;
          cmd.cnt_clr     = 1'b1;
        end
      end
      srdb_pkg::ST_EVAL: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          if (do_update) begin
            cmd.row_wr_op = srdb_pkg::ROW_WR_UPDATE;
          end
          if ((status.req_cmd == srdb_pkg::CMD_HIT) && status.way_ok) begin
            cmd.reuse_wr_op = srdb_pkg::REUSE_WR_INC;
          end
          // fetch the counter of the evicted line's signature for the penalty
          if (status.req_cmd == srdb_pkg::CMD_FILL) begin
            cmd.reuse_rd_en  = 1'b1;
            cmd.reuse_rd_old = 1'b1;
          end
        end
      end
      srdb_pkg::ST_PENALTY: begin
        cmd.reuse_wr_op = srdb_pkg::REUSE_WR_DEC;
      end
      srdb_pkg::ST_DECAY_RD: begin
        cmd.row_rd_en    = 1'b1;
        cmd.row_rd_sweep = 1'b1;
      end
      srdb_pkg::ST_DECAY_WR: begin
        cmd.row_wr_op = srdb_pkg::ROW_WR_DECAY;
        cmd.cnt_inc   = !status.cnt_last;
      end
      default: begin
        cmd.capture = 1'b0;
      end
    endcase
  end

endmodule

### design/srdb_dpath.sv
// ----------------------------------------------------------------------------
// srdb_dpath - replacement state and decision logic
// Holds the per-set row memory (rrpv, dead counter, signature per way), the
// signature reuse table, the request register, the victim search and the
// result register.
// ----------------------------------------------------------------------------
module srdb_dpath #(
  parameter int NUM_SETS  = 2048,
  parameter int NUM_WAYS  = 16,
  parameter int SIG_WIDTH = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_cmd,
  input  logic [srdb_pkg::IN_SET_W-1:0]     in_set_index,
  input  logic [srdb_pkg::IN_WAY_W-1:0]     in_way_index,
  input  logic [srdb_pkg::PC_W-1:0]         in_pc,
  input  logic [srdb_pkg::MASK_W-1:0]       in_valid_mask,
  input  logic                              in_victim_present,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [srdb_pkg::OUT_WAY_W-1:0]    out_victim_way,
  input  srdb_pkg::ctrl_cmd_t               cmd,
  output srdb_pkg::dp_status_t              status
);

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIG_WIDTH;
  localparam int MW        = (NUM_WAYS > srdb_pkg::MASK_W) ? NUM_WAYS : srdb_pkg::MASK_W;

  typedef logic [NUM_WAYS-1:0][1:0]           two_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_WIDTH-1:0] sig_row_t;

  // row memory, one row per set
  two_row_t rrpv_mem [NUM_SETS];
  two_row_t dead_mem [NUM_SETS];
  sig_row_t sig_mem  [NUM_SETS];

  // reuse table, entries not yet written read as the reset value
  logic [1:0]           reuse_mem [SIG_COUNT];
  logic [SIG_COUNT-1:0] reuse_vld_r;

  // request register
  logic [1:0]                  req_cmd_r;
  logic [SET_W-1:0]            req_set_r;
  logic [srdb_pkg::IN_WAY_W-1:0] req_way_r;
  logic [SIG_WIDTH-1:0]        req_sig_r;
  logic [srdb_pkg::MASK_W-1:0] req_mask_r;
  logic                        req_evict_r;

  two_row_t rd_rrpv_r;
  two_row_t rd_dead_r;
  sig_row_t rd_sig_r;
  logic [1:0] reuse_rd_r;
  logic       reuse_rd_vld_r;

  logic [SET_W-1:0] cnt_r;
  logic                           out_valid_r;
  logic [srdb_pkg::OUT_WAY_W-1:0] out_victim_r;

  logic [srdb_pkg::IN_SET_W-1:0] set_rem;
  logic [SET_W-1:0]    in_set;
  logic [SIG_WIDTH-1:0] in_sig;
  logic [MW-1:0]       mask_ext;
  logic [WAY_W-1:0]    way_idx;
  logic                way_ok;
  logic [1:0]          old_dead;
  logic [SIG_WIDTH-1:0] old_sig;
  logic [1:0]          reuse_val;

  logic             inv_found;
  logic             dead_found;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] dead_way;
  logic [WAY_W-1:0] r3_way;
  logic [WAY_W-1:0] victim;
  logic [1:0]       top;
  logic [1:0]       lift;
  two_row_t         lifted;
  logic             lift_needed;

  two_row_t upd_rrpv;
  two_row_t upd_dead;
  sig_row_t upd_sig;
  two_row_t dec_dead;
  two_row_t wr_rrpv;
  two_row_t wr_dead;
  sig_row_t wr_sig;
  logic             row_we;
  logic [SET_W-1:0] row_wa;
  logic [SET_W-1:0] row_ra;

  logic                 reuse_we;
  logic [SIG_WIDTH-1:0] reuse_wa;
  logic [SIG_WIDTH-1:0] reuse_ra;
  logic [1:0]           reuse_wd;

  // set index modulo the set count by restoring compare and subtract
  always_comb begin
    set_rem = in_set_index;
    for (int k = srdb_pkg::IN_SET_W - 1; k >= 0; k--) begin
      if ((NUM_SETS << k) < srdb_pkg::SET_SPAN) begin
        if (set_rem >= srdb_pkg::IN_SET_W'(NUM_SETS << k)) begin
          set_rem = set_rem - srdb_pkg::IN_SET_W'(NUM_SETS << k);
        end
      end
    end
  end

  assign in_set = SET_W'(set_rem);
  assign in_sig = in_pc[SIG_WIDTH-1:0] ^ in_pc[8 +: SIG_WIDTH] ^ in_pc[16 +: SIG_WIDTH];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd_r   <= in_cmd;
      req_set_r   <= in_set;
      req_way_r   <= in_way_index;
      req_sig_r   <= in_sig;
      req_mask_r  <= in_valid_mask;
      req_evict_r <= in_victim_present;
    end
  end

  // ways with no mask bit count as valid
  assign mask_ext = MW'({{MW{1'b1}}, req_mask_r});
  assign way_idx  = WAY_W'(req_way_r);
  assign way_ok   = (32'(req_way_r) < NUM_WAYS);
  assign old_dead = rd_dead_r[way_idx];
  assign old_sig  = rd_sig_r[way_idx];
  assign reuse_val = reuse_rd_vld_r ? reuse_rd_r : srdb_pkg::REUSE_RESET;

  // victim search over the row just read
  always_comb begin
    inv_found  = 1'b0;
    dead_found = 1'b0;
    inv_way    = '0;
    dead_way   = '0;
    r3_way     = '0;
    top        = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!inv_found && !mask_ext[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (!dead_found && (rd_dead_r[w] == '0)) begin
        dead_found = 1'b1;
        dead_way   = WAY_W'(w);
      end
      if (rd_rrpv_r[w] > top) begin
        top = rd_rrpv_r[w];
      end
    end
    lift = srdb_pkg::RRPV_MAX - top;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      lifted[w] = rd_rrpv_r[w] + lift;
      if (lifted[w] == srdb_pkg::RRPV_MAX) begin
        r3_way = WAY_W'(w);
      end
    end
    if (inv_found) begin
      victim = inv_way;
    end else if (dead_found) begin
      victim = dead_way;
    end else begin
      victim = r3_way;
    end
    lift_needed = !inv_found && !dead_found && (top != srdb_pkg::RRPV_MAX);
  end

  // write-back row for the request
  always_comb begin
    upd_rrpv = (req_cmd_r == srdb_pkg::CMD_VICTIM) ? lifted : rd_rrpv_r;
    upd_dead = rd_dead_r;
    upd_sig  = rd_sig_r;
    if (req_cmd_r == srdb_pkg::CMD_HIT) begin
      upd_rrpv[way_idx] = '0;
      upd_dead[way_idx] = srdb_pkg::DEAD_MAX;
    end
    if (req_cmd_r == srdb_pkg::CMD_FILL) begin
      upd_rrpv[way_idx] = (reuse_val >= srdb_pkg::REUSE_HOT) ? 2'd0 : srdb_pkg::RRPV_MAX;
      upd_dead[way_idx] = srdb_pkg::DEAD_MAX;
      upd_sig[way_idx]  = req_sig_r;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      dec_dead[w] = (rd_dead_r[w] == '0) ? 2'd0 : rd_dead_r[w] - 2'd1;
    end
  end

  always_comb begin
    wr_rrpv = upd_rrpv;
    wr_dead = upd_dead;
    wr_sig  = upd_sig;
    row_wa  = cnt_r;
    case (cmd.row_wr_op)
      srdb_pkg::ROW_WR_CLEAR: begin
        wr_rrpv = '0;
        wr_dead = '0;
        wr_sig  = '0;
      end
      srdb_pkg::ROW_WR_UPDATE: begin
        row_wa = req_set_r;
      end
      srdb_pkg::ROW_WR_DECAY: begin
        wr_rrpv = rd_rrpv_r;
        wr_dead = dec_dead;
        wr_sig  = rd_sig_r;
      end
      default: begin
        row_wa = cnt_r;
      end
    endcase
  end

  assign row_we = (cmd.row_wr_op != srdb_pkg::ROW_WR_NONE);
  assign row_ra = cmd.row_rd_sweep ? cnt_r : in_set;

  always_ff @(posedge clk) begin
    if (row_we) begin
      rrpv_mem[row_wa] <= wr_rrpv;
      dead_mem[row_wa] <= wr_dead;
      sig_mem[row_wa]  <= wr_sig;
    end
    if (cmd.row_rd_en) begin
      rd_rrpv_r <= rrpv_mem[row_ra];
      rd_dead_r <= dead_mem[row_ra];
      rd_sig_r  <= sig_mem[row_ra];
    end
  end

  // reuse table access
  always_comb begin
    reuse_we = 1'b1;
    reuse_wa = old_sig;
    reuse_wd = reuse_val;
    case (cmd.reuse_wr_op)
      srdb_pkg::REUSE_WR_INC: begin
        reuse_wa = req_sig_r;
        reuse_wd = (reuse_val == srdb_pkg::REUSE_MAX) ? reuse_val : reuse_val + 2'd1;
      end
      srdb_pkg::REUSE_WR_DEC: begin
        reuse_wd = (reuse_val == '0) ? reuse_val : reuse_val - 2'd1;
      end
      default: begin
        reuse_we = 1'b0;
      end
    endcase
  end

  assign reuse_ra = cmd.reuse_rd_old ? old_sig : in_sig;

  always_ff @(posedge clk) begin
    if (reuse_we) begin
      reuse_mem[reuse_wa] <= reuse_wd;
    end
    if (cmd.reuse_rd_en) begin
      reuse_rd_r     <= reuse_mem[reuse_ra];
      reuse_rd_vld_r <= reuse_vld_r[reuse_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_vld_r <= '0;
    end else if (reuse_we) begin
      reuse_vld_r[reuse_wa] <= 1'b1;
    end
  end

  // sweep counter for the clearing pass and the decay tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + SET_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_victim_r <= (req_cmd_r == srdb_pkg::CMD_VICTIM) ?
                      srdb_pkg::OUT_WAY_W'(victim) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_victim_r;

  assign status.req_cmd     = req_cmd_r;
  assign status.way_ok      = way_ok;
  assign status.lift_needed = lift_needed;
  assign status.penalty     = req_evict_r && way_ok && (old_dead == '0);
  assign status.cnt_last    = (cnt_r == SET_W'(NUM_SETS - 1));
  assign status.out_free    = !out_valid_r || !out_stall;

endmodule

### design/ship_rrip_dead_block_replacement.sv
// ----------------------------------------------------------------------------
// ship_rrip_dead_block_replacement - cache replacement policy engine
// SHiP-lite RRIP with per-line dead block counters and a signature reuse table.
// ----------------------------------------------------------------------------
// victim, hit, fill: row read at accept, result registered in the decide step, which a
//   stalled result holds; a fill penalising a dead victim adds a penalty step after it
// decay tick: every set row read and written back, then a result loaded in decide
// all requests: in_stall stays high until the request is done, one request at a time
// reset: clearing pass of the row memory with in_stall high;
//   the reuse table reads as one until written
module ship_rrip_dead_block_replacement #(
  parameter int NUM_SETS  = 2048,
  parameter int NUM_WAYS  = 16,
  parameter int SIG_WIDTH = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [srdb_pkg::IN_SET_W-1:0]     in_set_index,
  input  logic [srdb_pkg::IN_WAY_W-1:0]     in_way_index,
  input  logic [srdb_pkg::PC_W-1:0]         in_pc,
  input  logic [srdb_pkg::MASK_W-1:0]       in_valid_mask,
  input  logic                              in_victim_present,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [srdb_pkg::OUT_WAY_W-1:0]    out_victim_way
);

  srdb_pkg::ctrl_cmd_t  cmd;
  srdb_pkg::dp_status_t status;

  srdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .status   (status),
    .cmd      (cmd)
  );

  srdb_dpath #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .SIG_WIDTH (SIG_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_set_index      (in_set_index),
    .in_way_index      (in_way_index),
    .in_pc             (in_pc),
    .in_valid_mask     (in_valid_mask),
    .in_victim_present (in_victim_present),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_victim_way    (out_victim_way),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
